@@ rtl/vac_pkg.sv @@
// vac_pkg: shared types, constants and helpers of the vertex attribute colorizer
// used by every rtl file of the block; depends on nothing
`default_nettype none

package vac_pkg;

    // register stages from input to output register
    localparam int STAGES = 4;

    localparam int CHECKER_CELLS_DEF = 8;

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    typedef enum logic [2:0] {
        MODE_SOLID   = 3'd0,
        MODE_NORMALS = 3'd1,
        MODE_HEIGHT  = 3'd2,
        MODE_WEIGHT  = 3'd3,
        MODE_UV      = 3'd4
    } color_mode_t;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic [STAGES-1:0] load;
    } vac_ctl_t;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
        logic signed [15:0] r;
        if (x > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/vac_ctrl.sv @@
// vac_ctrl: valid bits and per-stage load enables of the colorizer pipeline
// depends on vac_pkg
`default_nettype none

module vac_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output vac_pkg::vac_ctl_t     ctl
);
    import vac_pkg::*;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] upstream;
    logic              in_acc;
    logic              out_acc;

    // a stage takes a word when it is empty or its word moves on
    always_comb begin
        rdy[STAGES] = m_ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            rdy[i] = ~valid_reg[i] | rdy[i+1];
        end
    end

    assign upstream = {valid_reg[STAGES-2:0], s_valid};

    always_comb begin
        for (int i = 0; i < STAGES; i++) begin
            valid_next[i] = rdy[i] ? upstream[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load = rdy[STAGES-1:0];
    assign s_ready  = rdy[0];
    assign m_valid  = valid_reg[STAGES-1];
    assign in_acc   = s_valid & s_ready;
    assign out_acc  = m_valid & m_ready;

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg == '0) |-> s_ready)
        else $error("empty pipeline refuses a word");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&valid_reg) && !m_ready) |-> !s_ready)
        else $error("full stalled pipeline accepts a word");

    a_word_count: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> ($countones(valid_reg) == $past($countones(valid_reg))
                     + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("word lost or duplicated in pipeline");

endmodule

`default_nettype wire

@@ rtl/vac_btn.sv @@
// vac_btn: tangent pass-through and bitangent cross product pipeline
// depends on vac_pkg; stage loads come from vac_ctrl
`default_nettype none

module vac_btn (
    input  wire logic                aclk,
    input  wire vac_pkg::vac_ctl_t   ctl,
    input  wire logic signed [15:0]  normal_x,
    input  wire logic signed [15:0]  normal_y,
    input  wire logic signed [15:0]  normal_z,
    input  wire logic signed [15:0]  tangent_x,
    input  wire logic signed [15:0]  tangent_y,
    input  wire logic signed [15:0]  tangent_z,
    input  wire logic signed [15:0]  tangent_sign,
    input  wire logic                has_tangent,
    output logic signed [15:0]       tangent_out_x,
    output logic signed [15:0]       tangent_out_y,
    output logic signed [15:0]       tangent_out_z,
    output logic signed [15:0]       bitangent_x,
    output logic signed [15:0]       bitangent_y,
    output logic signed [15:0]       bitangent_z
);
    import vac_pkg::*;

    localparam logic signed [48:0] ROUND_HALF = 49'sd134217728;

    // stage 1: six partial products
    logic signed [31:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [15:0] tx1_reg, ty1_reg, tz1_reg, sg1_reg;
    logic               ht1_reg;
    // stage 2: cross product
    logic signed [32:0] cx_reg, cy_reg, cz_reg;
    logic signed [15:0] tx2_reg, ty2_reg, tz2_reg, sg2_reg;
    logic               ht2_reg;
    // stage 3: scaled by handedness
    logic signed [48:0] mx_reg, my_reg, mz_reg;
    logic signed [15:0] tx3_reg, ty3_reg, tz3_reg;
    logic               ht3_reg;
    // stage 4 combinational rounding
    logic signed [48:0] rx, ry, rz;

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            p0_reg  <= 32'(normal_y) * 32'(tangent_z);
            p1_reg  <= 32'(normal_z) * 32'(tangent_y);
            p2_reg  <= 32'(normal_z) * 32'(tangent_x);
            p3_reg  <= 32'(normal_x) * 32'(tangent_z);
            p4_reg  <= 32'(normal_x) * 32'(tangent_y);
            p5_reg  <= 32'(normal_y) * 32'(tangent_x);
            tx1_reg <= tangent_x;
            ty1_reg <= tangent_y;
            tz1_reg <= tangent_z;
            sg1_reg <= tangent_sign;
            ht1_reg <= has_tangent;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            cx_reg  <= 33'(p0_reg) - 33'(p1_reg);
            cy_reg  <= 33'(p2_reg) - 33'(p3_reg);
            cz_reg  <= 33'(p4_reg) - 33'(p5_reg);
            tx2_reg <= tx1_reg;
            ty2_reg <= ty1_reg;
            tz2_reg <= tz1_reg;
            sg2_reg <= sg1_reg;
            ht2_reg <= ht1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            mx_reg  <= 49'(cx_reg) * 49'(sg2_reg);
            my_reg  <= 49'(cy_reg) * 49'(sg2_reg);
            mz_reg  <= 49'(cz_reg) * 49'(sg2_reg);
            tx3_reg <= tx2_reg;
            ty3_reg <= ty2_reg;
            tz3_reg <= tz2_reg;
            ht3_reg <= ht2_reg;
        end
    end

    // round half up from 2^-42 units, then drop 28 bits
    assign rx = mx_reg + ROUND_HALF;
    assign ry = my_reg + ROUND_HALF;
    assign rz = mz_reg + ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            if (ht3_reg) begin
                tangent_out_x <= tx3_reg;
                tangent_out_y <= ty3_reg;
                tangent_out_z <= tz3_reg;
                bitangent_x   <= sat16({{11{rx[48]}}, rx[48:28]});
                bitangent_y   <= sat16({{11{ry[48]}}, ry[48:28]});
                bitangent_z   <= sat16({{11{rz[48]}}, rz[48:28]});
            end else begin
                tangent_out_x <= ONE_Q14;
                tangent_out_y <= '0;
                tangent_out_z <= '0;
                bitangent_x   <= '0;
                bitangent_y   <= ONE_Q14;
                bitangent_z   <= '0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/vac_color.sv @@
// vac_color: debug colour pipeline (solid, normals, height, weight, uv checker)
// depends on vac_pkg; stage loads come from vac_ctrl
`default_nettype none

module vac_color #(
    parameter int CHECKER_CELLS = vac_pkg::CHECKER_CELLS_DEF
) (
    input  wire logic                aclk,
    input  wire vac_pkg::vac_ctl_t   ctl,
    input  wire logic [2:0]          mode,
    input  wire logic signed [15:0]  normal_x,
    input  wire logic signed [15:0]  normal_y,
    input  wire logic signed [15:0]  normal_z,
    input  wire logic signed [23:0]  height_y,
    input  wire logic [15:0]         frac_u,
    input  wire logic [15:0]         frac_v,
    input  wire logic signed [15:0]  total_weight,
    output logic signed [15:0]       color_red,
    output logic signed [15:0]       color_green,
    output logic signed [15:0]       color_blue
);
    import vac_pkg::*;

    localparam int          CW    = $clog2(CHECKER_CELLS + 1);
    localparam int          PW    = 16 + CW;
    localparam logic [CW-1:0] CELLS = CW'(CHECKER_CELLS);

    localparam logic signed [25:0] SOLID_R  = 26'sd12288;
    localparam logic signed [25:0] SOLID_G  = 26'sd12452;
    localparam logic signed [25:0] SOLID_B  = 26'sd12780;
    localparam logic signed [25:0] HGT_G0   = 26'sd11469;
    localparam logic signed [25:0] ONE_W    = 26'sd16384;
    localparam logic [16:0]        WGT_NUM0 = 17'd65538;
    localparam logic [32:0]        RECIP5   = 33'd52429;
    localparam logic [14:0]        CHK_EVEN = 15'd16384;
    localparam logic [14:0]        CHK_ODD  = 15'd2458;
    localparam logic [16:0]        UV_BIAS  = 17'd819;
    localparam logic signed [25:0] UV_B_EVN = 26'sd7373;
    localparam logic signed [25:0] UV_B_ODD = 26'sd2499;

    // stage 1
    logic [PW-1:0]      cell_u, cell_v;
    logic [14:0]        w_clamp;
    logic [2:0]         mode1_reg;
    logic signed [15:0] nx1_reg, ny1_reg, nz1_reg;
    logic signed [24:0] t1_reg;
    logic [14:0]        w1_reg;
    logic [15:0]        fu1_reg, fv1_reg;
    logic               even1_reg;
    // stage 2
    logic signed [16:0] nxs, nys, nzs;
    logic signed [25:0] tw, tp1;
    logic [14:0]        chk;
    logic [2:0]         mode2_reg;
    logic signed [15:0] nr2_reg, ng2_reg, nb2_reg;
    logic signed [25:0] hr2_reg, hg2_reg, hb2_reg;
    logic [14:0]        w2_reg;
    logic [16:0]        wnum2_reg;
    logic [30:0]        pu2_reg, pv2_reg;
    logic               even2_reg;
    // stage 3
    logic [32:0]        wprod;
    logic [31:0]        uround, vround;
    logic [16:0]        uvr, uvg;
    logic signed [25:0] r3_next, g3_next, b3_next;
    logic signed [25:0] r3_reg, g3_reg, b3_reg;

    // checker cell parity is bit 16 of frac * cells
    assign cell_u = PW'(frac_u) * PW'(CELLS);
    assign cell_v = PW'(frac_v) * PW'(CELLS);

    always_comb begin
        if (total_weight < 16'sd0) begin
            w_clamp = '0;
        end else if (total_weight > ONE_Q14) begin
            w_clamp = 15'(ONE_Q14);
        end else begin
            w_clamp = total_weight[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            mode1_reg <= mode;
            nx1_reg   <= normal_x;
            ny1_reg   <= normal_y;
            nz1_reg   <= normal_z;
            t1_reg    <= {height_y[23], height_y} + 25'sd8192;
            w1_reg    <= w_clamp;
            fu1_reg   <= frac_u;
            fv1_reg   <= frac_v;
            even1_reg <= ~(cell_u[16] ^ cell_v[16]);
        end
    end

    // normals: (n + 16385) >> 1
    assign nxs = {nx1_reg[15], nx1_reg} + 17'sd16385;
    assign nys = {ny1_reg[15], ny1_reg} + 17'sd16385;
    assign nzs = {nz1_reg[15], nz1_reg} + 17'sd16385;
    // height green reduces to 11469 - ceil(t / 2)
    assign tw  = {t1_reg[24], t1_reg};
    assign tp1 = tw + 26'sd1;
    assign chk = even1_reg ? CHK_EVEN : CHK_ODD;

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            mode2_reg <= mode1_reg;
            nr2_reg   <= nxs[16:1];
            ng2_reg   <= nys[16:1];
            nb2_reg   <= nzs[16:1];
            hr2_reg   <= tw;
            hg2_reg   <= HGT_G0 - {tp1[25], tp1[25:1]};
            hb2_reg   <= ONE_W - tw;
            w2_reg    <= w1_reg;
            wnum2_reg <= WGT_NUM0 - (17'(w1_reg) * 17'd3);
            pu2_reg   <= 31'(fu1_reg) * 31'(chk);
            pv2_reg   <= 31'(fv1_reg) * 31'(chk);
            even2_reg <= even1_reg;
        end
    end

    // divide by 5 through the reciprocal, exact below 2^18
    assign wprod  = 33'(wnum2_reg) * RECIP5;
    assign uround = 32'(pu2_reg) + 32'd32768;
    assign vround = 32'(pv2_reg) + 32'd32768;
    assign uvr    = {1'b0, uround[31:16]} + UV_BIAS;
    assign uvg    = {1'b0, vround[31:16]} + UV_BIAS;

    always_comb begin
        unique case (mode2_reg)
            MODE_NORMALS: begin
                r3_next = 26'(nr2_reg);
                g3_next = 26'(ng2_reg);
                b3_next = 26'(nb2_reg);
            end
            MODE_HEIGHT: begin
                r3_next = hr2_reg;
                g3_next = hg2_reg;
                b3_next = hb2_reg;
            end
            MODE_WEIGHT: begin
                r3_next = {11'd0, w2_reg};
                g3_next = {11'd0, wprod[32:18]};
                b3_next = ONE_W - {11'd0, w2_reg};
            end
            MODE_UV: begin
                r3_next = {9'd0, uvr};
                g3_next = {9'd0, uvg};
                b3_next = even2_reg ? UV_B_EVN : UV_B_ODD;
            end
            default: begin
                r3_next = SOLID_R;
                g3_next = SOLID_G;
                b3_next = SOLID_B;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            r3_reg <= r3_next;
            g3_reg <= g3_next;
            b3_reg <= b3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            color_red   <= sat16({{6{r3_reg[25]}}, r3_reg});
            color_green <= sat16({{6{g3_reg[25]}}, g3_reg});
            color_blue  <= sat16({{6{b3_reg[25]}}, b3_reg});
        end
    end

endmodule

`default_nettype wire

@@ rtl/vertex_attribute_colorizer.sv @@
// vertex_attribute_colorizer: top level, mode register and pipeline wiring
// depends on vac_pkg, vac_ctrl, vac_btn and vac_color
//
// Takes one vertex per clock while the result side is not stalled and gives
// its tangent, bitangent and debug colour through the four register stages
// that both datapaths share (in vac_btn: products, cross difference,
// handedness multiply, round and saturate). Each stage holds its word while
// the one after it is full and cannot move on, so a stall on the result side
// fills empty stages first and loses nothing.
// The colour mode is sampled when a vertex enters, so a write to the mode
// register takes effect from the next accepted vertex.
`default_nettype none

module vertex_attribute_colorizer #(
    parameter int CHECKER_CELLS = vac_pkg::CHECKER_CELLS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_normal_x,
    input  wire logic signed [15:0] s_normal_y,
    input  wire logic signed [15:0] s_normal_z,
    input  wire logic signed [15:0] s_tangent_x,
    input  wire logic signed [15:0] s_tangent_y,
    input  wire logic signed [15:0] s_tangent_z,
    input  wire logic signed [15:0] s_tangent_sign,
    input  wire logic               s_has_tangent,
    input  wire logic signed [23:0] s_height_y,
    input  wire logic signed [23:0] s_tex_u,
    input  wire logic signed [23:0] s_tex_v,
    input  wire logic signed [15:0] s_total_weight,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_tangent_out_x,
    output logic signed [15:0]      m_tangent_out_y,
    output logic signed [15:0]      m_tangent_out_z,
    output logic signed [15:0]      m_bitangent_x,
    output logic signed [15:0]      m_bitangent_y,
    output logic signed [15:0]      m_bitangent_z,
    output logic signed [15:0]      m_color_red,
    output logic signed [15:0]      m_color_green,
    output logic signed [15:0]      m_color_blue
);
    import vac_pkg::*;

    logic [2:0] coloring_mode_reg;
    vac_ctl_t   ctl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coloring_mode_reg <= MODE_SOLID;
        end else if (cfg_wr_en) begin
            coloring_mode_reg <= cfg_wr_data;
        end
    end

    vac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    vac_btn u_btn (
        .aclk          (aclk),
        .ctl           (ctl),
        .normal_x      (s_normal_x),
        .normal_y      (s_normal_y),
        .normal_z      (s_normal_z),
        .tangent_x     (s_tangent_x),
        .tangent_y     (s_tangent_y),
        .tangent_z     (s_tangent_z),
        .tangent_sign  (s_tangent_sign),
        .has_tangent   (s_has_tangent),
        .tangent_out_x (m_tangent_out_x),
        .tangent_out_y (m_tangent_out_y),
        .tangent_out_z (m_tangent_out_z),
        .bitangent_x   (m_bitangent_x),
        .bitangent_y   (m_bitangent_y),
        .bitangent_z   (m_bitangent_z)
    );

    // only the fraction of each texture coordinate matters to the checker
    vac_color #(
        .CHECKER_CELLS (CHECKER_CELLS)
    ) u_color (
        .aclk         (aclk),
        .ctl          (ctl),
        .mode         (coloring_mode_reg),
        .normal_x     (s_normal_x),
        .normal_y     (s_normal_y),
        .normal_z     (s_normal_z),
        .height_y     (s_height_y),
        .frac_u       (s_tex_u[15:0]),
        .frac_v       (s_tex_v[15:0]),
        .total_weight (s_total_weight),
        .color_red    (m_color_red),
        .color_green  (m_color_green),
        .color_blue   (m_color_blue)
    );

endmodule

`default_nettype wire
